FILE: rtl/rycc_pkg.sv
// rycc_pkg: widths, types, coefficient tables and rounding helpers for the
// RGB <-> luma/chroma converter. No dependencies; every other file imports it.
`default_nettype none

package rycc_pkg;

   localparam int COMPONENT_WIDTH     = 16;
   localparam int COEFF_FRACTION_BITS = 14;

   localparam int W      = COMPONENT_WIDTH;
   localparam int CW     = COEFF_FRACTION_BITS + 2;  // coefficients stay below 2.0
   localparam int VW     = COMPONENT_WIDTH + 3;      // unsaturated intermediates
   localparam int PW     = VW + CW + 2;              // product sums
   localparam int STAGES = 8;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   typedef logic signed [W-1:0]      comp_type;
   typedef logic signed [CW-1:0]     coef_type;
   typedef logic signed [VW-1:0]     val_type;
   typedef logic signed [PW-1:0]     prod_type;
   typedef logic signed [W+CW-1:0]   mul1_type;
   typedef logic signed [VW+CW-1:0]  mul2_type;

   typedef enum logic [1:0] {
      MAT_709   = 2'd0,
      MAT_601   = 2'd1,
      MAT_2020  = 2'd2,
      MAT_YCOCG = 2'd3
   } matrix_type;

   typedef enum logic {
      DIR_FORWARD = 1'b0,
      DIR_INVERSE = 1'b1
   } dir_type;

   typedef struct packed {
      matrix_type matrix;
      dir_type    dir;
   } mode_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_MATRIX_SELECT = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION     = CSR_INDEX_W'(1);

   // Luma weights in units of 1/10000, per matrix.
   localparam longint ONE   = longint'(1) << COEFF_FRACTION_BITS;
   localparam longint SCALE = 10000;
   localparam longint WR [3] = '{2126, 2990, 2627};
   localparam longint WG [3] = '{7152, 5870, 6780};
   localparam longint WB [3] = '{722, 1140, 593};

   // round(n/d) half up: (2n + d) / (2d)
   localparam longint KR [3] = '{
      (2 * WR[0] * ONE + SCALE) / (2 * SCALE),
      (2 * WR[1] * ONE + SCALE) / (2 * SCALE),
      (2 * WR[2] * ONE + SCALE) / (2 * SCALE)};
   localparam longint KG [3] = '{
      (2 * WG[0] * ONE + SCALE) / (2 * SCALE),
      (2 * WG[1] * ONE + SCALE) / (2 * SCALE),
      (2 * WG[2] * ONE + SCALE) / (2 * SCALE)};
   localparam longint KB [3] = '{
      (2 * WB[0] * ONE + SCALE) / (2 * SCALE),
      (2 * WB[1] * ONE + SCALE) / (2 * SCALE),
      (2 * WB[2] * ONE + SCALE) / (2 * SCALE)};
   localparam longint RECIP_B [3] = '{
      (2 * ONE * SCALE + 2 * (SCALE - WB[0])) / (4 * (SCALE - WB[0])),
      (2 * ONE * SCALE + 2 * (SCALE - WB[1])) / (4 * (SCALE - WB[1])),
      (2 * ONE * SCALE + 2 * (SCALE - WB[2])) / (4 * (SCALE - WB[2]))};
   localparam longint RECIP_R [3] = '{
      (2 * ONE * SCALE + 2 * (SCALE - WR[0])) / (4 * (SCALE - WR[0])),
      (2 * ONE * SCALE + 2 * (SCALE - WR[1])) / (4 * (SCALE - WR[1])),
      (2 * ONE * SCALE + 2 * (SCALE - WR[2])) / (4 * (SCALE - WR[2]))};
   localparam longint MR [3] = '{
      (4 * ONE * (SCALE - WR[0]) + SCALE) / (2 * SCALE),
      (4 * ONE * (SCALE - WR[1]) + SCALE) / (2 * SCALE),
      (4 * ONE * (SCALE - WR[2]) + SCALE) / (2 * SCALE)};
   localparam longint MB [3] = '{
      (4 * ONE * (SCALE - WB[0]) + SCALE) / (2 * SCALE),
      (4 * ONE * (SCALE - WB[1]) + SCALE) / (2 * SCALE),
      (4 * ONE * (SCALE - WB[2]) + SCALE) / (2 * SCALE)};
   localparam longint INV_KG [3] = '{
      (2 * ONE * SCALE + WG[0]) / (2 * WG[0]),
      (2 * ONE * SCALE + WG[1]) / (2 * WG[1]),
      (2 * ONE * SCALE + WG[2]) / (2 * WG[2])};

   typedef struct packed {
      coef_type kr;
      coef_type kg;
      coef_type kb;
      coef_type mr;
      coef_type mb;
      coef_type recip_r;
      coef_type recip_b;
      coef_type inv_kg;
   } coef_set_type;

   localparam prod_type COMP_MAX = prod_type'((longint'(1) << (W - 1)) - 1);
   localparam prod_type COMP_MIN = -COMP_MAX - prod_type'(1);

   function automatic coef_set_type coef_sel(input matrix_type m);
      coef_set_type c;
      c = '0;
      if (m != MAT_YCOCG) begin
         c.kr      = coef_type'(KR[m]);
         c.kg      = coef_type'(KG[m]);
         c.kb      = coef_type'(KB[m]);
         c.mr      = coef_type'(MR[m]);
         c.mb      = coef_type'(MB[m]);
         c.recip_r = coef_type'(RECIP_R[m]);
         c.recip_b = coef_type'(RECIP_B[m]);
         c.inv_kg  = coef_type'(INV_KG[m]);
      end
      return c;
   endfunction

   // back to Q2.13, half toward plus infinity
   function automatic prod_type rnd_q(input prod_type x);
      prod_type h;
      h = prod_type'(1) <<< (COEFF_FRACTION_BITS - 1);
      return (x + h) >>> COEFF_FRACTION_BITS;
   endfunction

   function automatic comp_type sat_c(input prod_type x);
      comp_type r;
      if (x > COMP_MAX) begin
         r = comp_type'(COMP_MAX);
      end else if (x < COMP_MIN) begin
         r = comp_type'(COMP_MIN);
      end else begin
         r = x[W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/rycc_req_if.sv
// rycc_req_if: input pixel channel, valid/ready plus three components.
// Depends on rycc_pkg.
`default_nettype none

interface rycc_req_if;
   import rycc_pkg::*;

   logic     valid;
   logic     ready;
   comp_type in_a;
   comp_type in_b;
   comp_type in_c;

   modport source (output valid, output in_a, output in_b, output in_c, input ready);
   modport sink   (input valid, input in_a, input in_b, input in_c, output ready);
endinterface

`default_nettype wire

FILE: rtl/rycc_rsp_if.sv
// rycc_rsp_if: result pixel channel, valid/ready plus three components.
// Depends on rycc_pkg.
`default_nettype none

interface rycc_rsp_if;
   import rycc_pkg::*;

   logic     valid;
   logic     ready;
   comp_type out_a;
   comp_type out_b;
   comp_type out_c;

   modport source (output valid, output out_a, output out_b, output out_c, input ready);
   modport sink   (input valid, input out_a, input out_b, input out_c, output ready);
endinterface

`default_nettype wire

FILE: rtl/rycc_csr_if.sv
// rycc_csr_if: register write channel, valid/ready plus index and data.
// Depends on rycc_pkg.
`default_nettype none

interface rycc_csr_if;
   import rycc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/rycc_csr.sv
// rycc_csr: matrix_select and direction registers behind the write channel.
// Depends on rycc_pkg and rycc_csr_if.
`default_nettype none

module rycc_csr (
   input  logic               clock,
   input  logic               reset,
   rycc_csr_if.sink           csr,
   output rycc_pkg::mode_type mode
);
   import rycc_pkg::*;

   matrix_type matrix_ff;
   dir_type    dir_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= MAT_709;
         dir_ff    <= DIR_FORWARD;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_MATRIX_SELECT: matrix_ff <= matrix_type'(csr.data[1:0]);
            CSR_DIRECTION:     dir_ff    <= dir_type'(csr.data[0]);
            default: ;
         endcase
      end
   end

   assign mode.matrix = matrix_ff;
   assign mode.dir    = dir_ff;

endmodule

`default_nettype wire

FILE: rtl/rycc_pipe_ctl.sv
// rycc_pipe_ctl: per-stage valid bits and load enables for the pixel pipeline.
// Depends on rycc_pkg.
`default_nettype none

module rycc_pipe_ctl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [rycc_pkg::STAGES-1:0] en
);
   import rycc_pkg::*;

   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] v_in;
   logic              in_fire;
   logic              out_fire;

   // a stage loads when it is empty or its content moves on
   always_comb begin
      en[STAGES-1] = !v_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[0] = en[0] ? in_valid : v_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[STAGES-1];
   assign in_fire   = in_valid && in_ready;
   assign out_fire  = out_valid && out_ready;

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (in_fire && !out_fire) |=> ($countones(v_ff) == $past($countones(v_ff)) + 1))
      else $error("item count did not grow on accept");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (!in_fire && out_fire) |=> ($countones(v_ff) + 1 == $past($countones(v_ff))))
      else $error("item count did not shrink on delivery");

   a_ready_on_bubble: assert property (@(posedge clock) disable iff (reset)
      ($countones(v_ff) < STAGES) |-> in_ready)
      else $error("input stalled while a stage is empty");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (v_ff == '0))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

FILE: rtl/rycc_datapath.sv
// rycc_datapath: eight-stage arithmetic for both directions and all matrices.
// Depends on rycc_pkg; stage enables come from rycc_pipe_ctl.
`default_nettype none

module rycc_datapath (
   input  logic                        clock,
   input  logic [rycc_pkg::STAGES-1:0] en,
   input  rycc_pkg::mode_type          mode,
   input  rycc_pkg::comp_type          in_a,
   input  rycc_pkg::comp_type          in_b,
   input  rycc_pkg::comp_type          in_c,
   output rycc_pkg::comp_type          out_a,
   output rycc_pkg::comp_type          out_b,
   output rycc_pkg::comp_type          out_c
);
   import rycc_pkg::*;

   // stage 0: capture
   comp_type     a0_ff, b0_ff, c0_ff;
   mode_type     mode0_ff;
   coef_set_type k0_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         a0_ff    <= in_a;
         b0_ff    <= in_b;
         c0_ff    <= in_c;
         mode0_ff <= mode;
         k0_ff    <= coef_sel(mode.matrix);
      end
   end

   // stage 1: first products
   coef_type     m0, m1, m2;
   logic         inv0;
   mul1_type     p0_ff, p1_ff, p2_ff;
   comp_type     a1_ff, b1_ff, c1_ff;
   mode_type     mode1_ff;
   coef_set_type k1_ff;

   always_comb begin
      inv0 = (mode0_ff.dir == DIR_INVERSE);
      m0   = inv0 ? coef_type'(0) : k0_ff.kr;
      m1   = inv0 ? k0_ff.mb : k0_ff.kg;
      m2   = inv0 ? k0_ff.mr : k0_ff.kb;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         p0_ff    <= m0 * a0_ff;
         p1_ff    <= m1 * b0_ff;
         p2_ff    <= m2 * c0_ff;
         a1_ff    <= a0_ff;
         b1_ff    <= b0_ff;
         c1_ff    <= c0_ff;
         mode1_ff <= mode0_ff;
         k1_ff    <= k0_ff;
      end
   end

   // stage 2: luma (forward), R and B (inverse), YCoCg
   prod_type     sum2, ry2, rr2, rb2;
   val_type      ea1, eb1, ec1, t1;
   val_type      x2_in, z2_in, ya2_in, yb2_in, yc2_in;
   val_type      x2_ff, z2_ff, ya2_ff, yb2_ff, yc2_ff;
   comp_type     a2_ff, c2_ff;
   mode_type     mode2_ff;
   coef_set_type k2_ff;

   always_comb begin
      sum2 = prod_type'(p0_ff) + prod_type'(p1_ff) + prod_type'(p2_ff);
      ry2  = rnd_q(sum2);
      rr2  = rnd_q(prod_type'(p2_ff));
      rb2  = rnd_q(prod_type'(p1_ff));
      ea1  = val_type'(a1_ff);
      eb1  = val_type'(b1_ff);
      ec1  = val_type'(c1_ff);
      t1   = ea1 - ec1;
      if (mode1_ff.dir == DIR_INVERSE) begin
         x2_in  = ea1 + val_type'(rr2[VW-1:0]);
         z2_in  = ea1 + val_type'(rb2[VW-1:0]);
         ya2_in = t1 + eb1;
         yb2_in = ea1 + ec1;
         yc2_in = t1 - eb1;
      end else begin
         x2_in  = val_type'(ry2[VW-1:0]);
         z2_in  = '0;
         ya2_in = (ea1 + (eb1 <<< 1) + ec1 + val_type'(2)) >>> 2;
         yb2_in = (ea1 - ec1 + val_type'(1)) >>> 1;
         yc2_in = ((eb1 <<< 1) - ea1 - ec1 + val_type'(2)) >>> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         x2_ff    <= x2_in;
         z2_ff    <= z2_in;
         ya2_ff   <= ya2_in;
         yb2_ff   <= yb2_in;
         yc2_ff   <= yc2_in;
         a2_ff    <= a1_ff;
         c2_ff    <= c1_ff;
         mode2_ff <= mode1_ff;
         k2_ff    <= k1_ff;
      end
   end

   // stage 3: second multiplier operands
   val_type      ur3_in, ub3_in;
   val_type      ur3_ff, ub3_ff, x3_ff, z3_ff, ya3_ff, yb3_ff, yc3_ff;
   comp_type     a3_ff;
   mode_type     mode3_ff;
   coef_set_type k3_ff;

   always_comb begin
      if (mode2_ff.dir == DIR_INVERSE) begin
         ur3_in = x2_ff;
         ub3_in = z2_ff;
      end else begin
         ur3_in = val_type'(a2_ff) - x2_ff;
         ub3_in = val_type'(c2_ff) - x2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         ur3_ff   <= ur3_in;
         ub3_ff   <= ub3_in;
         x3_ff    <= x2_ff;
         z3_ff    <= z2_ff;
         ya3_ff   <= ya2_ff;
         yb3_ff   <= yb2_ff;
         yc3_ff   <= yc2_ff;
         a3_ff    <= a2_ff;
         mode3_ff <= mode2_ff;
         k3_ff    <= k2_ff;
      end
   end

   // stage 4: second products
   coef_type cr3, cb3;
   mul2_type qr4_ff, qb4_ff;
   val_type  x4_ff, z4_ff, ya4_ff, yb4_ff, yc4_ff;
   comp_type a4_ff;
   mode_type mode4_ff;
   coef_type inv_kg4_ff;

   always_comb begin
      cr3 = (mode3_ff.dir == DIR_INVERSE) ? k3_ff.kr : k3_ff.recip_r;
      cb3 = (mode3_ff.dir == DIR_INVERSE) ? k3_ff.kb : k3_ff.recip_b;
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         qr4_ff     <= cr3 * ur3_ff;
         qb4_ff     <= cb3 * ub3_ff;
         x4_ff      <= x3_ff;
         z4_ff      <= z3_ff;
         ya4_ff     <= ya3_ff;
         yb4_ff     <= yb3_ff;
         yc4_ff     <= yc3_ff;
         a4_ff      <= a3_ff;
         mode4_ff   <= mode3_ff;
         inv_kg4_ff <= k3_ff.inv_kg;
      end
   end

   // stage 5: chroma (forward), green numerator (inverse)
   prod_type rqr4, rqb4, tsum4, rt4;
   val_type  wa5_in, wb5_in, wc5_in;
   val_type  wa5_ff, wb5_ff, wc5_ff;
   mode_type mode5_ff;
   coef_type inv_kg5_ff;

   always_comb begin
      rqr4  = rnd_q(prod_type'(qr4_ff));
      rqb4  = rnd_q(prod_type'(qb4_ff));
      tsum4 = (prod_type'(a4_ff) <<< COEFF_FRACTION_BITS)
              - prod_type'(qr4_ff) - prod_type'(qb4_ff);
      rt4   = rnd_q(tsum4);
      if (mode4_ff.matrix == MAT_YCOCG) begin
         wa5_in = ya4_ff;
         wb5_in = yb4_ff;
         wc5_in = yc4_ff;
      end else if (mode4_ff.dir == DIR_INVERSE) begin
         wa5_in = x4_ff;
         wb5_in = val_type'(rt4[VW-1:0]);
         wc5_in = z4_ff;
      end else begin
         wa5_in = x4_ff;
         wb5_in = val_type'(rqb4[VW-1:0]);
         wc5_in = val_type'(rqr4[VW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         wa5_ff     <= wa5_in;
         wb5_ff     <= wb5_in;
         wc5_ff     <= wc5_in;
         mode5_ff   <= mode4_ff;
         inv_kg5_ff <= inv_kg4_ff;
      end
   end

   // stage 6: green product
   mul2_type g6_ff;
   val_type  wa6_ff, wb6_ff, wc6_ff;
   mode_type mode6_ff;

   always_ff @(posedge clock) begin
      if (en[6]) begin
         g6_ff    <= inv_kg5_ff * wb5_ff;
         wa6_ff   <= wa5_ff;
         wb6_ff   <= wb5_ff;
         wc6_ff   <= wc5_ff;
         mode6_ff <= mode5_ff;
      end
   end

   // stage 7: final rounding and saturation
   logic     use_g6;
   prod_type rg6, b7_in;
   comp_type out_a_ff, out_b_ff, out_c_ff;

   always_comb begin
      use_g6 = (mode6_ff.dir == DIR_INVERSE) && (mode6_ff.matrix != MAT_YCOCG);
      rg6    = rnd_q(prod_type'(g6_ff));
      b7_in  = use_g6 ? rg6 : prod_type'(wb6_ff);
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         out_a_ff <= sat_c(prod_type'(wa6_ff));
         out_b_ff <= sat_c(b7_in);
         out_c_ff <= sat_c(prod_type'(wc6_ff));
      end
   end

   assign out_a = out_a_ff;
   assign out_b = out_b_ff;
   assign out_c = out_c_ff;

endmodule

`default_nettype wire

FILE: rtl/rgb_ycc_colour_converter.sv
// rgb_ycc_colour_converter: RGB <-> luma/chroma converter.
// Usage:
//   req_chan carries one pixel item (in_a, in_b, in_c, signed Q2.13) with
//   valid/ready; rsp_chan returns one converted item (out_a, out_b, out_c),
//   saturated. csr_chan writes matrix_select (index 0: Rec.709, Rec.601,
//   Rec.2020, YCoCg) and direction (index 1: forward or inverse); write only
//   while no item is in flight. Writes to other indexes are dropped.
//   An item passes through the eight register stages (three multiply stages
//   interleaved with add/round stages) before rsp_chan.valid rises; throughput
//   is one pixel item per cycle while rsp_chan.ready stays high.
//   Reset (synchronous, active high) empties the pipeline and sets both
//   registers to zero (Rec.709, forward).
//   When rsp_chan.ready is low the last stage holds its item; earlier stages
//   keep advancing into empty slots, so req_chan.ready drops only when all
//   eight stages hold items.
// Depends on rycc_pkg, the three channel interfaces, rycc_csr, rycc_pipe_ctl
// and rycc_datapath.
`default_nettype none

module rgb_ycc_colour_converter (
   input  logic        clock,
   input  logic        reset,
   rycc_req_if.sink    req_chan,
   rycc_rsp_if.source  rsp_chan,
   rycc_csr_if.sink    csr_chan
);
   import rycc_pkg::*;

   mode_type          mode;
   logic [STAGES-1:0] en;

   rycc_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_chan),
      .mode  (mode)
   );

   rycc_pipe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .en        (en)
   );

   rycc_datapath u_dp (
      .clock (clock),
      .en    (en),
      .mode  (mode),
      .in_a  (req_chan.in_a),
      .in_b  (req_chan.in_b),
      .in_c  (req_chan.in_c),
      .out_a (rsp_chan.out_a),
      .out_b (rsp_chan.out_b),
      .out_c (rsp_chan.out_c)
   );

endmodule

`default_nettype wire

FILE: dv/rycc_conversion_checker.sv
// rycc_conversion_checker: watches the pixel, result and register channels of the
// converter, predicts every converted pixel and compares it with what comes out.
// Depends on rycc_pkg; the testbench top instantiates it beside the block.
`default_nettype none

module rycc_conversion_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  rycc_pkg::comp_type               req_a,
   input  rycc_pkg::comp_type               req_b,
   input  rycc_pkg::comp_type               req_c,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  rycc_pkg::comp_type               rsp_a,
   input  rycc_pkg::comp_type               rsp_b,
   input  rycc_pkg::comp_type               rsp_c,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [rycc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rycc_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                               mismatch_count,
   output int                               in_flight
);
   import rycc_pkg::*;

   typedef struct packed {
      comp_type a;
      comp_type b;
      comp_type c;
   } pixel_type;

   // luma weights in 1/10000: Rec.709, Rec.601, Rec.2020
   localparam longint LUMA_R [3] = '{2126, 2990, 2627};
   localparam longint LUMA_G [3] = '{7152, 5870, 6780};
   localparam longint LUMA_B [3] = '{722, 1140, 593};
   localparam longint DENOM      = 10000;
   localparam int     FRAC       = COEFF_FRACTION_BITS;

   matrix_type cur_matrix;
   dir_type    cur_dir;
   pixel_type  predicted_pixels [$];
   pixel_type  want_px;
   pixel_type  got_px;
   pixel_type  req_px;

   function automatic longint half_up_shift(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   // nearest integer of n/d, ties upward, positive operands
   function automatic longint quotient_rounded(input longint n, input longint d);
      return (2 * n + d) / (2 * d);
   endfunction

   function automatic comp_type clip_component(input longint x);
      longint hi;
      longint lo;
      hi = (longint'(1) << (COMPONENT_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) x = hi;
      if (x < lo) x = lo;
      return comp_type'(x);
   endfunction

   function automatic pixel_type convert_pixel(input matrix_type m, input dir_type d,
                                               input pixel_type px);
      longint a, b, c, ra, rb, rc, one, kr, kg, kb, y, r, bl, t;
      longint wr, wg, wb, recip_b, recip_r, mr, mb, inv_kg;
      pixel_type res;
      a   = px.a;
      b   = px.b;
      c   = px.c;
      one = longint'(1) << FRAC;
      if (m == MAT_YCOCG) begin
         if (d == DIR_FORWARD) begin
            ra = half_up_shift(a + 2 * b + c, 2);
            rb = half_up_shift(a - c, 1);
            rc = half_up_shift(-a + 2 * b - c, 2);
         end else begin
            t  = a - c;
            ra = t + b;
            rb = a + c;
            rc = t - b;
         end
      end else begin
         wr = LUMA_R[int'(m)];
         wg = LUMA_G[int'(m)];
         wb = LUMA_B[int'(m)];
         kr = quotient_rounded(wr * one, DENOM);
         kg = quotient_rounded(wg * one, DENOM);
         kb = quotient_rounded(wb * one, DENOM);
         if (d == DIR_FORWARD) begin
            recip_b = quotient_rounded(one * DENOM, 2 * (DENOM - wb));
            recip_r = quotient_rounded(one * DENOM, 2 * (DENOM - wr));
            y  = half_up_shift(kr * a + kg * b + kb * c, FRAC);
            ra = y;
            rb = half_up_shift((c - y) * recip_b, FRAC);
            rc = half_up_shift((a - y) * recip_r, FRAC);
         end else begin
            mr     = quotient_rounded(one * 2 * (DENOM - wr), DENOM);
            mb     = quotient_rounded(one * 2 * (DENOM - wb), DENOM);
            inv_kg = quotient_rounded(one * DENOM, wg);
            r  = a + half_up_shift(mr * c, FRAC);
            bl = a + half_up_shift(mb * b, FRAC);
            t  = half_up_shift(a * one - kr * r - kb * bl, FRAC);
            ra = r;
            rb = half_up_shift(t * inv_kg, FRAC);
            rc = bl;
         end
      end
      res.a = clip_component(ra);
      res.b = clip_component(rb);
      res.c = clip_component(rc);
      return res;
   endfunction

   task automatic check_component(input string field, input comp_type want,
                                  input comp_type got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   initial begin
      mismatch_count = 0;
      in_flight      = 0;
      cur_matrix     = MAT_709;
      cur_dir        = DIR_FORWARD;
   end

   always @(posedge clock) begin
      if (reset) begin
         cur_matrix = MAT_709;
         cur_dir    = DIR_FORWARD;
         predicted_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MATRIX_SELECT) cur_matrix = matrix_type'(csr_data[1:0]);
            else if (csr_index == CSR_DIRECTION) cur_dir = dir_type'(csr_data[0]);
         end
         if (rsp_valid && rsp_ready) begin
            got_px = '{rsp_a, rsp_b, rsp_c};
            if (predicted_pixels.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected item, expected none, actual %0d %0d %0d",
                        $time, rsp_a, rsp_b, rsp_c);
            end else begin
               want_px = predicted_pixels.pop_front();
               check_component("out_a", want_px.a, got_px.a);
               check_component("out_b", want_px.b, got_px.b);
               check_component("out_c", want_px.c, got_px.c);
            end
         end
         if (req_valid && req_ready) begin
            req_px = '{req_a, req_b, req_c};
            predicted_pixels.push_back(convert_pixel(cur_matrix, cur_dir, req_px));
         end
      end
      in_flight = predicted_pixels.size();
   end

endmodule

`default_nettype wire

FILE: dv/rgb_ycc_colour_converter_tb.sv
// rgb_ycc_colour_converter_tb: drives pixels and register writes into the converter
// under random gaps and stalls, then reports the checker's verdict.
// Depends on rycc_pkg, the three channel interfaces and rycc_conversion_checker.
`default_nettype none

module rgb_ycc_colour_converter_tb;
   import rycc_pkg::*;

   localparam int PIPE_DEPTH = 8;

   localparam comp_type CORNER_A [8] = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                                         16'sh0000, 16'sh0001, 16'shFFFF, 16'sh2000};
   localparam comp_type CORNER_B [8] = '{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
                                         16'sh0000, 16'sh0000, 16'sh0000, 16'sh2000};
   localparam comp_type CORNER_C [8] = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                                         16'sh0000, 16'sh0001, 16'shFFFF, 16'sh2000};

   logic clock;
   logic reset;
   int   mismatch_count;
   int   in_flight;
   int   gap_max;
   int   stall_max;
   int   choke_cycles;

   rycc_req_if req_chan ();
   rycc_rsp_if rsp_chan ();
   rycc_csr_if csr_chan ();

   rgb_ycc_colour_converter u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   rycc_conversion_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_a          (req_chan.in_a),
      .req_b          (req_chan.in_b),
      .req_c          (req_chan.in_c),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_a          (rsp_chan.out_a),
      .rsp_b          (rsp_chan.out_b),
      .rsp_c          (rsp_chan.out_c),
      .csr_valid      (csr_chan.valid),
      .csr_ready      (csr_chan.ready),
      .csr_index      (csr_chan.index),
      .csr_data       (csr_chan.data),
      .mismatch_count (mismatch_count),
      .in_flight      (in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int draw_pause(input int limit);
      return (limit == 0) ? 0 : $urandom_range(0, limit);
   endfunction

   function automatic comp_type pick_component();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         4, 5, 6: return comp_type'(int'($urandom_range(0, 16384)) - 8192);
         7:       return comp_type'(int'($urandom_range(0, 8)) - 4);
         8:       return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
         9:       return comp_type'(int'($urandom_range(0, 8192)) - 4096);
         default: return comp_type'($urandom);
      endcase
   endfunction

   // result side: per-item stall, plus an occasional long hold-off
   initial begin
      int hold;
      bit took;
      hold = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         took = rsp_chan.valid && rsp_chan.ready && !reset;
         @(negedge clock);
         if (took) hold = draw_pause(stall_max);
         if (hold == 0 && choke_cycles > 0) begin
            hold = choke_cycles;
            choke_cycles = 0;
         end
         if (hold > 0) begin
            rsp_chan.ready = 1'b0;
            hold--;
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   // entered and left at a falling edge
   task automatic send_pixel(input comp_type a, input comp_type b, input comp_type c);
      int gap;
      gap = draw_pause(gap_max);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.in_a  = a;
      req_chan.in_b  = b;
      req_chan.in_c  = c;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_chan.valid = 1'b1;
      csr_chan.index = index;
      csr_chan.data  = data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   task automatic drain();
      req_chan.valid = 1'b0;
      while (in_flight != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 2) @(negedge clock);
   endtask

   // upper data bits are junk; only the register width is kept
   task automatic set_mode(input matrix_type m, input dir_type d);
      logic [CSR_DATA_W-1:0] data;
      drain();
      data      = CSR_DATA_W'($urandom);
      data[1:0] = m;
      write_reg(CSR_MATRIX_SELECT, data);
      if ($urandom_range(0, 2) == 0)
         write_reg(CSR_INDEX_W'($urandom_range(2, 15)), CSR_DATA_W'($urandom));
      data    = CSR_DATA_W'($urandom);
      data[0] = d;
      write_reg(CSR_DIRECTION, data);
   endtask

   initial begin
      int mode;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.in_a  = '0;
      req_chan.in_b  = '0;
      req_chan.in_c  = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data  = '0;
      gap_max        = 0;
      stall_max      = 0;
      choke_cycles   = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // corners, saturation and rounding ties under every mode
      for (int s = 0; s < 8; s++) begin
         set_mode(matrix_type'(s % 4), dir_type'(s / 4));
         for (int k = 0; k < 3; k++)
            send_pixel(CORNER_A[(s * 3 + k) % 8], CORNER_B[(s * 3 + k) % 8],
                       CORNER_C[(s * 3 + k) % 8]);
      end

      for (int ph = 0; ph < 10; ph++) begin
         mode = (ph < 8) ? (ph * 3) % 8 : $urandom_range(0, 7);
         set_mode(matrix_type'(mode % 4), dir_type'(mode / 4));
         gap_max   = (ph % 3 == 0) ? 0 : 10;
         stall_max = (ph % 4 == 1) ? 0 : 10;
         if (ph == 2 || ph == 7) begin
            gap_max      = 2;
            choke_cycles = $urandom_range(150, 300);
         end
         repeat (185) send_pixel(pick_component(), pick_component(), pick_component());
      end

      drain();
      repeat (4 * PIPE_DEPTH) @(negedge clock);
      if (mismatch_count == 0 && in_flight == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
